/* design/mdet_pkg.sv */
`default_nettype none

package mdet_pkg;

    localparam int MAX_SIZE    = 4;
    localparam int STORE_DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ROW_W       = $clog2(MAX_SIZE);
    localparam int SIZE_W      = 3;
    localparam int SQ_W        = 2 * SIZE_W;
    localparam int PERM_W      = 5;
    localparam int ENTRY_W     = 16;
    localparam int DET_W       = 64;
    // Product of three entries still fits in 48 bits signed.
    localparam int PART_W      = 48;
    // |det| <= 24 * 2^60, so 68 bits hold the exact sum.
    localparam int ACC_W       = 68;
    localparam int DRAIN_W     = 2;

    localparam logic [DRAIN_W-1:0] DRAIN_LAST = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic                  neg;
        logic [3:0][ROW_W-1:0] col;
    } perm_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [PERM_W-1:0] perm;
        logic [ROW_W-1:0]  row;
        logic [SIZE_W-1:0] n;
        logic              first;
        logic              last;
        logic              clear;
        logic              latch;
    } dp_cmd_t;

    // Permutations of four columns, ordered so that the first n! of them
    // fix every row from n up: the first n! entries serve an n x n matrix.
    // Packed as {neg, col3, col2, col1, col0}.
    function automatic perm_t perm_entry(input logic [PERM_W-1:0] idx);
        perm_t pe;
        case (idx)
            5'd0:    pe = {1'b0, 2'd3, 2'd2, 2'd1, 2'd0};
            5'd1:    pe = {1'b1, 2'd3, 2'd2, 2'd0, 2'd1};
            5'd2:    pe = {1'b1, 2'd3, 2'd1, 2'd2, 2'd0};
            5'd3:    pe = {1'b0, 2'd3, 2'd0, 2'd2, 2'd1};
            5'd4:    pe = {1'b0, 2'd3, 2'd1, 2'd0, 2'd2};
            5'd5:    pe = {1'b1, 2'd3, 2'd0, 2'd1, 2'd2};
            5'd6:    pe = {1'b1, 2'd2, 2'd3, 2'd1, 2'd0};
            5'd7:    pe = {1'b0, 2'd1, 2'd3, 2'd2, 2'd0};
            5'd8:    pe = {1'b0, 2'd2, 2'd1, 2'd3, 2'd0};
            5'd9:    pe = {1'b1, 2'd1, 2'd2, 2'd3, 2'd0};
            5'd10:   pe = {1'b0, 2'd2, 2'd3, 2'd0, 2'd1};
            5'd11:   pe = {1'b1, 2'd0, 2'd3, 2'd2, 2'd1};
            5'd12:   pe = {1'b1, 2'd2, 2'd0, 2'd3, 2'd1};
            5'd13:   pe = {1'b0, 2'd0, 2'd2, 2'd3, 2'd1};
            5'd14:   pe = {1'b1, 2'd1, 2'd3, 2'd0, 2'd2};
            5'd15:   pe = {1'b0, 2'd0, 2'd3, 2'd1, 2'd2};
            5'd16:   pe = {1'b0, 2'd1, 2'd0, 2'd3, 2'd2};
            5'd17:   pe = {1'b1, 2'd0, 2'd1, 2'd3, 2'd2};
            5'd18:   pe = {1'b1, 2'd2, 2'd1, 2'd0, 2'd3};
            5'd19:   pe = {1'b0, 2'd1, 2'd2, 2'd0, 2'd3};
            5'd20:   pe = {1'b0, 2'd2, 2'd0, 2'd1, 2'd3};
            5'd21:   pe = {1'b1, 2'd0, 2'd2, 2'd1, 2'd3};
            5'd22:   pe = {1'b1, 2'd1, 2'd0, 2'd2, 2'd3};
            5'd23:   pe = {1'b0, 2'd0, 2'd1, 2'd2, 2'd3};
            default: pe = {1'b0, 2'd3, 2'd2, 2'd1, 2'd0};
        endcase
        return pe;
    endfunction

    // n! for the sizes in use
    function automatic logic [PERM_W-1:0] perm_count(input logic [SIZE_W-1:0] n);
        logic [PERM_W-1:0] cnt;
        case (n)
            3'd1:    cnt = 5'd1;
            3'd2:    cnt = 5'd2;
            3'd3:    cnt = 5'd6;
            default: cnt = 5'd24;
        endcase
        return cnt;
    endfunction

endpackage

`default_nettype wire

/* design/matrix_determinant.sv */
`default_nettype none

// Exact determinant of an n x n matrix of signed 16-bit entries, n = 1..4
// from the matrix_size register (0 acts as 1, above 4 acts as 4). Entries
// come in row-major order, one word per cycle while busy is low; the word
// is taken at a clock edge with start high and busy low. The last entry
// starts the computation and raises busy. The result is the sum over all
// n! column permutations of the signed product of n entries, accumulated
// exactly and then saturated to signed 64 bits; saturated flags a clipped
// value. The computation runs one store read and one multiply per cycle
// through a single 48x16 multiplier fed by the one read port of the entry
// store, and then drains the pipeline. The result is shown for exactly
// one cycle with result_valid high; the receiver cannot stall it, so it
// must take the word in that cycle. busy is already low in that cycle
// and the next matrix may start loading. matrix_size is written through
// cfg_valid/cfg_ready while busy is low; changing it in the middle of a
// load keeps the entries already counted.
module matrix_determinant (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [mdet_pkg::ENTRY_W-1:0]  entry_value,
    output logic                                 result_valid,
    output logic signed [mdet_pkg::DET_W-1:0]    determinant,
    output logic                                 saturated,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mdet_pkg::SIZE_W-1:0]          cfg_data
);
    import mdet_pkg::*;

    dp_cmd_t cmd;

    // sequencing: load count, permutation/row counters, drain
    mdet_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    // entry store, product pipeline, accumulator, saturation
    mdet_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .entry_value  (entry_value),
        .determinant  (determinant),
        .saturated    (saturated),
        .result_valid (result_valid)
    );

endmodule

`default_nettype wire

/* design/mdet_ctrl.sv */
`default_nettype none

module mdet_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          cfg_valid,
    input  logic [mdet_pkg::SIZE_W-1:0]   cfg_data,
    output logic                          busy,
    output logic                          cfg_ready,
    output mdet_pkg::dp_cmd_t             cmd
);
    import mdet_pkg::*;

    state_t              state_reg, state_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [ADDR_W-1:0]   count_reg, count_next;
    logic [PERM_W-1:0]   perm_reg, perm_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [DRAIN_W-1:0]  drain_reg, drain_next;

    logic [SIZE_W-1:0]   n_eff;
    logic [SQ_W-1:0]     sq;
    logic                accept;
    logic                last_entry;
    logic                row_last;
    logic                perm_last;

    always_comb
    begin
        if (size_reg == '0)
            n_eff = SIZE_W'(1);
        else if (size_reg > SIZE_W'(MAX_SIZE))
            n_eff = SIZE_W'(MAX_SIZE);
        else
            n_eff = size_reg;
    end

    assign sq         = SQ_W'(n_eff) * SQ_W'(n_eff);
    assign accept     = start && (state_reg == ST_IDLE);
    assign last_entry = (SQ_W'(count_reg) + SQ_W'(1)) >= sq;
    assign row_last   = SIZE_W'(row_reg) == (n_eff - SIZE_W'(1));
    assign perm_last  = perm_reg == (perm_count(n_eff) - PERM_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && last_entry)
                    state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                if (row_last && perm_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (drain_reg == DRAIN_LAST)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // counters and size register
    always_comb
    begin
        size_next  = size_reg;
        count_next = count_reg;
        perm_next  = perm_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        if (cfg_valid && cfg_ready)
            size_next = cfg_data;
        case (state_reg)
            ST_IDLE:
            begin
                perm_next  = '0;
                row_next   = '0;
                drain_next = '0;
                if (accept)
                    count_next = last_entry ? '0 : count_reg + ADDR_W'(1);
            end
            ST_ISSUE:
            begin
                if (row_last)
                begin
                    row_next  = '0;
                    perm_next = perm_reg + PERM_W'(1);
                end
                else
                    row_next = row_reg + ROW_W'(1);
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + DRAIN_W'(1);
            end
            default: ;
        endcase
    end

    // outputs
    always_comb
    begin
        busy          = state_reg != ST_IDLE;
        cfg_ready     = state_reg == ST_IDLE;
        cmd.wr_en     = accept;
        cmd.wr_addr   = count_reg;
        cmd.rd_en     = state_reg == ST_ISSUE;
        cmd.perm      = perm_reg;
        cmd.row       = row_reg;
        cmd.n         = n_eff;
        cmd.first     = row_reg == '0;
        cmd.last      = row_last;
        cmd.clear     = accept && last_entry;
        cmd.latch     = (state_reg == ST_DRAIN) && (drain_reg == DRAIN_LAST);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            size_reg  <= SIZE_W'(MAX_SIZE);
            count_reg <= '0;
            perm_reg  <= '0;
            row_reg   <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
            count_reg <= count_next;
            perm_reg  <= perm_next;
            row_reg   <= row_next;
            drain_reg <= drain_next;
        end
    end

endmodule

`default_nettype wire

/* design/mdet_dp.sv */
`default_nettype none

module mdet_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mdet_pkg::dp_cmd_t                    cmd,
    input  logic signed [mdet_pkg::ENTRY_W-1:0]  entry_value,
    output logic signed [mdet_pkg::DET_W-1:0]    determinant,
    output logic                                 saturated,
    output logic                                 result_valid
);
    import mdet_pkg::*;

    logic [ENTRY_W-1:0]        mem [STORE_DEPTH];

    perm_t                     pe;
    logic [ROW_W-1:0]          col;
    logic [ADDR_W-1:0]         rd_addr;

    // stage 1: store read
    logic signed [ENTRY_W-1:0] rd_data_reg;
    logic                      s1_valid_reg;
    logic                      s1_first_reg, s1_last_reg, s1_neg_reg;

    // stage 2: running product
    logic signed [PART_W-1:0]  mul_a;
    logic signed [DET_W-1:0]   mul_res;
    logic signed [DET_W-1:0]   prod_reg, prod_next;
    logic                      s2_last_reg;
    logic                      s2_neg_reg;

    // stage 3: accumulate
    logic signed [ACC_W-1:0]   term;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;

    logic                      fits;
    logic signed [DET_W-1:0]   det_sat;
    logic signed [DET_W-1:0]   det_reg;
    logic                      sat_reg;
    logic                      sat_flag;
    logic                      valid_reg;

    assign pe      = perm_entry(cmd.perm);
    assign col     = pe.col[cmd.row];
    assign rd_addr = ADDR_W'(cmd.row) * ADDR_W'(cmd.n) + ADDR_W'(col);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[cmd.wr_addr] <= entry_value;
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= cmd.first;
        s1_last_reg  <= cmd.last;
        s1_neg_reg   <= pe.neg;
    end

    assign mul_a   = prod_reg[PART_W-1:0];
    assign mul_res = DET_W'(mul_a) * DET_W'(rd_data_reg);

    always_comb
    begin
        if (s1_first_reg)
            prod_next = DET_W'(rd_data_reg);
        else
            prod_next = mul_res;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            prod_reg   <= prod_next;
            s2_neg_reg <= s1_neg_reg;
        end
    end

    assign term = ACC_W'(prod_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.clear)
            acc_next = '0;
        else if (s2_last_reg)
            acc_next = s2_neg_reg ? acc_reg - term : acc_reg + term;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // saturate to 64 bits: top bits must all match the sign
    assign fits = (&acc_reg[ACC_W-1:DET_W-1]) || !(|acc_reg[ACC_W-1:DET_W-1]);

    always_comb
    begin
        sat_flag = 1'b0;
        if (fits)
            det_sat = acc_reg[DET_W-1:0];
        else
        begin
            sat_flag = 1'b1;
            if (acc_reg[ACC_W-1])
                det_sat = {1'b1, {(DET_W-1){1'b0}}};
            else
                det_sat = {1'b0, {(DET_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            det_reg <= det_sat;
            sat_reg <= sat_flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.rd_en;
            s2_last_reg  <= s1_valid_reg && s1_last_reg;
            valid_reg    <= cmd.latch;
        end
    end

    assign determinant  = det_reg;
    assign saturated    = sat_reg;
    assign result_valid = valid_reg;

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    import mdet_pkg::*;

    localparam int  RANDOM_ENTRIES = 1600;
    // Longest compute (4x4) with some margin
    localparam int  SETTLE_CYCLES  = 110;
    localparam int  MAX_GAP        = 19;
    localparam real RUN_LIMIT_NS   = 5_000_000.0;

    // Entry patterns for the random part
    typedef enum int {
        PAT_RANDOM,
        PAT_SIGNS
    } entry_pattern_t;

    typedef struct packed {
        logic [DET_W-1:0] det;
        logic             sat;
    } det_word_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic signed [ENTRY_W-1:0]  entry_value = '0;
    logic                       cfg_valid = 1'b0;
    logic [SIZE_W-1:0]          cfg_data = '0;
    logic                       busy;
    logic                       result_valid;
    logic signed [DET_W-1:0]    determinant;
    logic                       saturated;
    logic                       cfg_ready;

    // Predictor state: what the block should hold
    logic signed [ENTRY_W-1:0]  matrix_entries [STORE_DEPTH];
    int                         loaded_count = 0;
    logic [SIZE_W-1:0]          size_reg = 3'd4;

    det_word_t                  expected_dets [$];

    // Run bookkeeping
    int  mismatches = 0;
    int  entries_sent = 0;
    int  dets_checked = 0;
    int  sat_high_seen = 0;
    int  sat_low_seen = 0;
    bit  gaps_on = 1'b0;

    matrix_determinant u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .entry_value  (entry_value),
        .result_valid (result_valid),
        .determinant  (determinant),
        .saturated    (saturated),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // 0 acts as 1, anything above MAX_SIZE acts as MAX_SIZE
    function automatic int active_size();
        int n;
        n = int'(size_reg);
        if (n < 1)
            n = 1;
        if (n > MAX_SIZE)
            n = MAX_SIZE;
        return n;
    endfunction

    // Exact determinant over all column permutations. Same sum as the
    // first-row cofactor expansion; 128 bits never wrap for 4x4 of 16-bit.
    function automatic logic signed [127:0] exact_det(input int n);
        logic signed [127:0] sum;
        logic signed [127:0] prod;
        int                  col [MAX_SIZE];
        int                  combos;
        int                  idx;
        int                  rest;
        int                  inv;
        int                  i;
        int                  j;
        bit                  distinct;
        sum = '0;
        combos = 1;
        for (i = 0; i < n; i++)
            combos = combos * n;
        for (idx = 0; idx < combos; idx++)
        begin
            rest = idx;
            for (i = 0; i < n; i++)
            begin
                col[i] = rest % n;
                rest = rest / n;
            end
            distinct = 1'b1;
            inv = 0;
            for (i = 0; i < n; i++)
                for (j = i + 1; j < n; j++)
                begin
                    if (col[i] == col[j])
                        distinct = 1'b0;
                    else if (col[i] > col[j])
                        inv++;
                end
            if (distinct)
            begin
                prod = 128'sd1;
                for (i = 0; i < n; i++)
                    prod = prod * matrix_entries[i * n + col[i]];
                if (inv % 2 == 1)
                    sum = sum - prod;
                else
                    sum = sum + prod;
            end
        end
        return sum;
    endfunction

    // Book one accepted word; queue a determinant when the matrix completes
    task automatic take_entry(input logic signed [ENTRY_W-1:0] v);
        logic signed [127:0] exact;
        logic signed [127:0] top;
        det_word_t           w;
        int                  n;
        n = active_size();
        top = 128'sh7FFF_FFFF_FFFF_FFFF;
        entries_sent++;
        if (loaded_count < STORE_DEPTH)
            matrix_entries[loaded_count] = v;
        if (loaded_count + 1 < n * n)
        begin
            loaded_count++;
        end
        else
        begin
            loaded_count = 0;
            exact = exact_det(n);
            if (exact > top)
            begin
                w.det = 64'h7FFF_FFFF_FFFF_FFFF;
                w.sat = 1'b1;
            end
            else if (exact < -top - 128'sd1)
            begin
                w.det = 64'h8000_0000_0000_0000;
                w.sat = 1'b1;
            end
            else
            begin
                w.det = exact[DET_W-1:0];
                w.sat = 1'b0;
            end
            expected_dets.push_back(w);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: the word is only there for one cycle, take it now
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        det_word_t w;
        if (rst_n && result_valid)
        begin
            if (expected_dets.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result det=%0d sat=%0b",
                         $time, determinant, saturated);
            end
            else
            begin
                w = expected_dets.pop_front();
                dets_checked++;
                if (w.sat && !w.det[DET_W-1])
                    sat_high_seen++;
                if (w.sat && w.det[DET_W-1])
                    sat_low_seen++;
                if (determinant !== w.det)
                begin
                    mismatches++;
                    $display("%0t: determinant expected %0d actual %0d",
                             $time, $signed(w.det), determinant);
                end
                if (saturated !== w.sat)
                begin
                    mismatches++;
                    $display("%0t: saturated expected %0b actual %0b",
                             $time, w.sat, saturated);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Send one entry; optional random gap before it. start stays high
    // afterwards, so back-to-back words follow one another directly.
    task automatic load_entry(input logic signed [ENTRY_W-1:0] v);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        entry_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        take_entry(v);
    endtask

    // Stop sending and hold until every queued determinant has come out
    task automatic wait_results();
        start <= 1'b0;
        @(posedge clk);
        while (expected_dets.size() != 0)
            @(posedge clk);
    endtask

    // Size writes only with the block quiet
    task automatic write_size(input logic [SIZE_W-1:0] sz);
        int gap;
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        repeat (gap) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= sz;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        size_reg = sz;
    endtask

    // Sylvester 4x4 sign matrix at full scale; each flip bit negates a row
    function automatic logic signed [ENTRY_W-1:0] sign_entry(input int row,
                                                             input int col,
                                                             input logic [3:0] flips);
        logic [1:0] r;
        logic [1:0] c;
        r = row[1:0];
        c = col[1:0];
        if ((^(r & c)) ^ flips[row])
            return -16'sd32768;
        return 16'sd32767;
    endfunction

    function automatic logic signed [ENTRY_W-1:0] pick_entry(input entry_pattern_t pat,
                                                             input int n,
                                                             input int pos,
                                                             input logic [3:0] flips);
        int sel;
        if (pat == PAT_SIGNS && n == MAX_SIZE && pos < STORE_DEPTH)
            return sign_entry(pos / n, pos % n, flips);
        if (pat == PAT_SIGNS)
            return $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return 16'sd0;
            3, 4, 5: return 16'($signed($urandom_range(0, 6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] random_size();
        int sel;
        sel = $urandom_range(0, 11);
        if (sel == 0)
            return 3'd0;
        if (sel == 1)
            return 3'($urandom_range(5, 7));
        return 3'($urandom_range(1, 4));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset size is 4; the full-scale sign matrix overflows 64 bits
    task automatic test_saturation();
        int k;
        gaps_on = 1'b0;
        for (k = 0; k < 16; k++)
            load_entry(sign_entry(k / 4, k % 4, 4'b0000));
    endtask

    // 1x1 returns the entry; size 0 behaves as 1
    task automatic test_single_entry();
        gaps_on = 1'b0;
        write_size(3'd1);
        load_entry(-16'sd32768);
        load_entry(16'sd32767);
        write_size(3'd0);
        load_entry(16'sd0);
    endtask

    // Shrinking the size mid-load keeps the count: next word finishes it
    task automatic test_size_change();
        gaps_on = 1'b1;
        write_size(3'd2);
        load_entry(16'sd32767);
        load_entry(-16'sd32768);
        write_size(3'd1);
        load_entry(16'sd1);
        write_size(3'd2);
        load_entry(-16'sd32768);
        load_entry(16'sd32767);
        load_entry(16'sd32767);
        load_entry(-16'sd32768);
    endtask

    // Mostly whole matrices with random content, some cut short by a
    // size write, idle gaps on in most phases
    task automatic test_random_matrices();
        int             target;
        int             mats;
        int             m;
        int             n;
        int             left;
        int             k;
        entry_pattern_t pat;
        logic [3:0]     flips;
        bit             cut;
        target = entries_sent + RANDOM_ENTRIES;
        while (entries_sent < target)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            write_size(random_size());
            mats = $urandom_range(1, 6);
            cut = 1'b0;
            for (m = 0; m < mats && !cut; m++)
            begin
                n = active_size();
                pat = ($urandom_range(0, 7) == 0) ? PAT_SIGNS : PAT_RANDOM;
                flips = 4'($urandom);
                left = (loaded_count + 1 >= n * n) ? 1 : n * n - loaded_count;
                cut = ($urandom_range(0, 11) == 0) && left > 1;
                if (cut)
                    left = $urandom_range(0, left - 1);
                for (k = 0; k < left; k++)
                    load_entry(pick_entry(pat, n, loaded_count, flips));
                // occasional full stop to let the block drain
                if ($urandom_range(0, 19) == 0)
                    wait_results();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_saturation();
        test_single_entry();
        test_size_change();
        test_random_matrices();

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run: %0d entry words sent, %0d determinants checked",
                 entries_sent, dets_checked);
        $display("run: %0d clipped high, %0d clipped low, %0d mismatches",
                 sat_high_seen, sat_low_seen, mismatches);
        if (mismatches == 0)
            $display("matrix_determinant: match");
        else
            $display("matrix_determinant: mismatch");
        $finish;
    end

    // Hang guard
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("timeout: %0d determinants still pending", expected_dets.size());
        $display("matrix_determinant: mismatch");
        $finish;
    end

endmodule
